// ===== rtl/csed_pkg.sv =====
// ----------------------------------------------------------------------------
// csed_pkg: shared types and constants for the chronograph display block
// register indexes, reset values, commands, modes, states and seven-segment glyphs
// ----------------------------------------------------------------------------
`default_nettype none
package csed_pkg;

  localparam int NUM_DIGITS_DEF = 4;
  localparam int CFG_AW = 5;

  localparam logic [2:0] REG_SPEED_NUM = 3'd0;
  localparam logic [2:0] REG_ENERGY_DIV = 3'd1;
  localparam logic [2:0] REG_HALF_SEC = 3'd2;
  localparam logic [2:0] REG_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_ALT = 3'd4;

  localparam logic [23:0] SPEED_NUM_RST = 24'd100000;
  localparam logic [15:0] ENERGY_DIV_RST = 16'd2000;
  localparam logic [7:0] HALF_SEC_RST = 8'd128;
  localparam logic [3:0] TIMEOUT_RST = 4'd10;
  localparam logic [15:0] ALT_RST = 16'd640;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  localparam logic [1:0] MODE_WAIT = 2'd0;
  localparam logic [1:0] MODE_MEASURE = 2'd1;
  localparam logic [1:0] MODE_RESULT = 2'd2;

  localparam logic [7:0] SEG_BLANK = 8'h00;
  localparam logic [7:0] SEG_E = 8'h79;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SDIV = 5'b00010,
    ST_SQR  = 5'b00100,
    ST_EDIV = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  function automatic logic [7:0] digit_glyph(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'd0: g = 8'h3F;
      4'd1: g = 8'h06;
      4'd2: g = 8'h5B;
      4'd3: g = 8'h4F;
      4'd4: g = 8'h66;
      4'd5: g = 8'h6D;
      4'd6: g = 8'h7D;
      4'd7: g = 8'h07;
      4'd8: g = 8'h7F;
      4'd9: g = 8'h6F;
      default: g = SEG_BLANK;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] anim_glyph(input logic [1:0] a);
    logic [7:0] g;
    case (a)
      2'd1: g = 8'h40;
      2'd2: g = 8'h08;
      default: g = 8'h01;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/chronograph_speed_energy_display.sv =====
// ----------------------------------------------------------------------------
// chronograph_speed_energy_display
// light-gate chronograph with speed/energy calc and 4-digit multiplexed display
// ----------------------------------------------------------------------------
// A tick, a start or an ignored stop item is dispatched the cycle after it is
// accepted and its result item is valid the cycle after that.
// A stop item that computes runs through one shared shift-subtract divider
// twice: 24 steps for speed, then 32 steps on the square for energy. After
// dispatch come the speed division, the speed update, the square load and the
// energy division, and then the result item is valid. A stop with zero time
// skips the speed division. The divider takes one step per cycle.
// in_tready is low from acceptance until the result item is taken.
`default_nettype none
module chronograph_speed_energy_display #(
  parameter int NUM_DIGITS = csed_pkg::NUM_DIGITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] command, [17:2] stop_count, [18] start_sensor_low, [19] stop_sensor_low
  input  wire logic [23:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [1:0] digit_select, [9:2] segments, [11:10] measure_state,
  // [27:12] speed_value, [43:28] energy_value, [44] zero_time_flag
  output logic [47:0]      out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [csed_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import csed_pkg::*;

  localparam int SW = $clog2(NUM_DIGITS);

  logic [23:0] spd_num_r;
  logic [15:0] en_div_r, alt_r;
  logic [7:0]  half_r;
  logic [3:0]  tmo_r;

  state_t      st_r;
  logic [1:0]  mode_r;
  logic [SW-1:0] scan_r;
  logic [7:0]  per_r;
  logic [3:0]  tcnt_r;
  logic [1:0]  anim_r;
  logic [15:0] speed_r, energy_r;
  logic [16:0] phase_r;
  logic        zero_r;
  logic [1:0]  cmd_r;
  logic [15:0] cnt_r;
  logic        ssl_r, psl_r;
  logic [7:0]  seg_r;

  // shared divider: remainder, quotient/dividend, divisor, step counter
  logic [32:0] rem_r;
  logic [31:0] quo_r;
  logic [23:0] dvs_r;
  logic [5:0]  step_r;

  logic [2:0]  ridx;
  assign ridx = cfg_paddr[CFG_AW-1:2];
  assign cfg_pready = 1'b1;

  always_comb begin
    case (ridx)
      REG_SPEED_NUM:  cfg_prdata = {8'd0, spd_num_r};
      REG_ENERGY_DIV: cfg_prdata = {16'd0, en_div_r};
      REG_HALF_SEC:   cfg_prdata = {24'd0, half_r};
      REG_TIMEOUT:    cfg_prdata = {28'd0, tmo_r};
      REG_ALT:        cfg_prdata = {16'd0, alt_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_num_r <= SPEED_NUM_RST;
      en_div_r <= ENERGY_DIV_RST;
      half_r <= HALF_SEC_RST;
      tmo_r <= TIMEOUT_RST;
      alt_r <= ALT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (ridx)
        REG_SPEED_NUM:  spd_num_r <= cfg_pwdata[23:0];
        REG_ENERGY_DIV: en_div_r <= cfg_pwdata[15:0];
        REG_HALF_SEC:   half_r <= cfg_pwdata[7:0];
        REG_TIMEOUT:    tmo_r <= cfg_pwdata[3:0];
        REG_ALT:        alt_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign in_tready = (st_r == ST_IDLE);
  assign out_tvalid = (st_r == ST_OUT);
  assign out_tdata = {3'd0, zero_r, energy_r, speed_r, mode_r, seg_r, scan_r};

  // divider step
  logic [32:0] trial;
  logic [32:0] shifted;
  assign shifted = {rem_r[31:0], quo_r[31]};
  assign trial = shifted - {9'd0, dvs_r};

  // tick path
  logic [SW-1:0] scan_nxt;
  logic [15:0]   dval;
  logic [7:0]    seg_nxt;
  logic [16:0]   ph_inc;
  logic [7:0]    per_inc;
  logic [3:0]    tc_inc;
  assign scan_nxt = scan_r + SW'(1);
  assign dval = ({1'b0, phase_r} < {1'b0, alt_r, 1'b0} >> 1) ? speed_r : energy_r;
  assign ph_inc = phase_r + 17'd1;
  assign per_inc = per_r + 8'd1;
  assign tc_inc = tcnt_r + 4'd1;

  // decimal digits by reciprocal multiplication, exact over 16 bits
  logic [32:0] q1000_prod, q100_prod;
  logic [31:0] q10_prod;
  logic [6:0]  q1000;
  logic [9:0]  q100;
  logic [12:0] q10;
  logic [9:0]  hund_w;
  logic [12:0] tens_w;
  logic [15:0] unit_w;
  assign q1000_prod = {17'd0, dval} * 33'd67109;
  assign q100_prod = {17'd0, dval} * 33'd83887;
  assign q10_prod = {16'd0, dval} * 32'd52429;
  assign q1000 = q1000_prod[32:26];
  assign q100 = q100_prod[32:23];
  assign q10 = q10_prod[31:19];
  assign hund_w = q100 - {q1000, 3'd0} - {2'd0, q1000, 1'b0};
  assign tens_w = q10 - {q100, 3'd0} - {2'd0, q100, 1'b0};
  assign unit_w = dval - {q10, 3'd0} - {2'd0, q10, 1'b0};

  always_comb begin
    seg_nxt = SEG_BLANK;
    if (mode_r == MODE_WAIT) seg_nxt = anim_glyph(anim_r);
    else if (mode_r == MODE_RESULT && scan_nxt != SW'(3)) begin
      case (scan_nxt)
        SW'(0):  seg_nxt = digit_glyph(hund_w[3:0]);
        SW'(1):  seg_nxt = digit_glyph(tens_w[3:0]);
        default: seg_nxt = digit_glyph(unit_w[3:0]);
      endcase
    end
    if (ssl_r && scan_nxt == SW'(0)) seg_nxt = SEG_E;
    if (psl_r && scan_nxt == SW'(3)) seg_nxt = SEG_E;
  end

  logic [31:0] sq;
  assign sq = speed_r * speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      mode_r <= MODE_WAIT;
      scan_r <= '0;
      per_r <= '0;
      tcnt_r <= '0;
      anim_r <= '0;
      speed_r <= '0;
      energy_r <= '0;
      phase_r <= '0;
      zero_r <= 1'b0;
      seg_r <= SEG_BLANK;
      cmd_r <= CMD_TICK;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            cmd_r <= in_tdata[1:0];
            cnt_r <= in_tdata[17:2];
            ssl_r <= in_tdata[18];
            psl_r <= in_tdata[19];
            seg_r <= SEG_BLANK;
            st_r <= ST_SQR;
          end
        end
        ST_SQR: begin
          // first pass after accept: dispatch by command
          if (cmd_r == CMD_START) begin
            mode_r <= MODE_MEASURE;
            st_r <= ST_OUT;
          end else if (cmd_r == CMD_STOP) begin
            if (mode_r == MODE_WAIT) st_r <= ST_OUT;
            else if (cnt_r[15:1] == 15'd0) begin
              zero_r <= 1'b1;
              speed_r <= 16'hFFFF;
              cmd_r <= CMD_START;
              st_r <= ST_EDIV;
              step_r <= '0;
            end else begin
              zero_r <= 1'b0;
              rem_r <= '0;
              quo_r <= {spd_num_r, 8'd0};
              dvs_r <= {9'd0, cnt_r[15:1]};
              step_r <= 6'd24;
              st_r <= ST_SDIV;
            end
          end else begin
            scan_r <= scan_nxt;
            seg_r <= seg_nxt;
            if (mode_r == MODE_RESULT)
              phase_r <= ({1'b0, ph_inc} >= {1'b0, alt_r, 1'b0}) ? '0 : ph_inc;
            per_r <= (per_inc >= half_r) ? '0 : per_inc;
            if (per_inc >= half_r) begin
              anim_r <= (anim_r >= 2'd2) ? 2'd0 : anim_r + 2'd1;
              if (mode_r != MODE_MEASURE) begin
                tcnt_r <= (tc_inc >= tmo_r) ? '0 : tc_inc;
                if (tc_inc >= tmo_r) mode_r <= MODE_WAIT;
              end
            end
            st_r <= ST_OUT;
          end
        end
        ST_SDIV: begin
          rem_r <= trial[32] ? shifted : trial;
          quo_r <= {quo_r[30:0], ~trial[32]};
          step_r <= step_r - 6'd1;
          if (step_r == 6'd1) begin
            st_r <= ST_EDIV;
            cmd_r <= CMD_START;
          end
        end
        ST_EDIV: begin
          if (cmd_r == CMD_START) begin
            // speed ready: store speed, saturated to 16 bits; the square load follows
            if (cmd_r == CMD_START && step_r == '0 && !zero_r)
              speed_r <= (quo_r[23:16] != 8'd0) ? 16'hFFFF : quo_r[15:0];
            cmd_r <= CMD_STOP;
          end else if (cmd_r == CMD_STOP) begin
            rem_r <= '0;
            quo_r <= sq;
            dvs_r <= {8'd0, en_div_r};
            step_r <= 6'd32;
            cmd_r <= CMD_TICK;
          end else if (step_r != '0) begin
            rem_r <= trial[32] ? shifted : trial;
            quo_r <= {quo_r[30:0], ~trial[32]};
            step_r <= step_r - 6'd1;
          end else begin
            energy_r <= (quo_r[31:16] != 16'd0) ? 16'hFFFF : quo_r[15:0];
            phase_r <= '0;
            mode_r <= MODE_RESULT;
            st_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_tready) st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) !(in_tready && out_tvalid))
    else $error("ready while result pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n) mode_r != 2'd3)
    else $error("bad mode code");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EDIV) |-> (mode_r != MODE_WAIT))
    else $error("computing while waiting");

endmodule
`default_nettype wire
